@@ hw/rtl/lmcs_pkg.sv @@
// ----------------------------------------------------------------------------
// LED matrix column scroller package
// Opcodes, driver register addresses, broadcast sequence steps and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package lmcs_pkg;

  localparam logic [3:0] OP_INIT      = 4'd0;
  localparam logic [3:0] OP_INTENSITY = 4'd1;
  localparam logic [3:0] OP_CLEAR     = 4'd2;
  localparam logic [3:0] OP_SET_COL   = 4'd3;
  localparam logic [3:0] OP_SET_DOT   = 4'd4;
  localparam logic [3:0] OP_LEFT      = 4'd5;
  localparam logic [3:0] OP_RIGHT     = 4'd6;
  localparam logic [3:0] OP_UP        = 4'd7;
  localparam logic [3:0] OP_DOWN      = 4'd8;

  localparam logic [3:0] REG_DIGIT_FIRST = 4'h1;
  localparam logic [3:0] REG_DIGIT_LAST  = 4'h8;
  localparam logic [3:0] REG_DECODE      = 4'h9;
  localparam logic [3:0] REG_INTENSITY   = 4'hA;
  localparam logic [3:0] REG_SCAN        = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN    = 4'hC;
  localparam logic [3:0] REG_TEST        = 4'hF;

  localparam logic [7:0] SCAN_ALL_DIGITS = 8'h07;
  localparam logic [7:0] SHUTDOWN_NORMAL = 8'h01;

  // Broadcast sequence: setup writes, then the eight digit clears; intensity is a step of its own.
  localparam logic [3:0] BC_SCAN        = 4'd0;
  localparam logic [3:0] BC_DECODE      = 4'd1;
  localparam logic [3:0] BC_TEST        = 4'd2;
  localparam logic [3:0] BC_SHUTDOWN    = 4'd3;
  localparam logic [3:0] BC_DIGIT_FIRST = 4'd4;
  localparam logic [3:0] BC_DIGIT_LAST  = 4'd11;
  localparam logic [3:0] BC_INTENSITY   = 4'd12;

  localparam int unsigned DEV_CNT_W = 3;

  typedef struct packed {
    logic       load_item;
    logic       clr_store;
    logic       rd_en;
    logic       save_en;
    logic       emit_col;
    logic       emit_bc;
    logic       last;
    logic [3:0] bc_step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_range;
  } dp_sts_t;

  function automatic logic [3:0] bc_addr(input logic [3:0] step);
    logic [3:0] addr;
    unique case (step)
      BC_SCAN:      addr = REG_SCAN;
      BC_DECODE:    addr = REG_DECODE;
      BC_TEST:      addr = REG_TEST;
      BC_SHUTDOWN:  addr = REG_SHUTDOWN;
      BC_INTENSITY: addr = REG_INTENSITY;
      default:      addr = step - BC_DIGIT_FIRST + REG_DIGIT_FIRST;
    endcase
    return addr;
  endfunction

  function automatic logic [7:0] bc_data(input logic [3:0] step, input logic [7:0] value);
    logic [7:0] data;
    unique case (step)
      BC_SCAN:      data = SCAN_ALL_DIGITS;
      BC_SHUTDOWN:  data = SHUTDOWN_NORMAL;
      BC_INTENSITY: data = {4'd0, value[3:0]};
      default:      data = 8'd0;
    endcase
    return data;
  endfunction

endpackage

@@ hw/rtl/lmcs_datapath.sv @@
// ----------------------------------------------------------------------------
// LED matrix column scroller datapath
// Column store with registered read, item registers, column update logic
// and the output frame register.
// ----------------------------------------------------------------------------
module lmcs_datapath #(
  parameter int unsigned MAX_DEVICES = 4,
  localparam int unsigned NCOLS = MAX_DEVICES * 8,
  localparam int unsigned IDX_W = $clog2(NCOLS)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lmcs_pkg::dp_cmd_t              cmd_i,
  output lmcs_pkg::dp_sts_t              sts_o,
  input  logic [IDX_W-1:0]               rd_addr_i,
  input  logic [IDX_W-1:0]               idx_i,
  output logic [IDX_W-1:0]               nlast_o,
  input  logic [lmcs_pkg::DEV_CNT_W-1:0] dev_cnt_i,
  input  logic [3:0]                     op_i,
  input  logic [4:0]                     column_i,
  input  logic [2:0]                     row_i,
  input  logic [7:0]                     value_i,
  input  logic                           rotate_i,
  input  logic                           fill_zero_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           to_all_o,
  output logic [1:0]                     device_o,
  output logic [3:0]                     reg_addr_o,
  output logic [7:0]                     reg_data_o,
  output logic                           last_o
);
  import lmcs_pkg::*;

  logic [7:0]       mem_q [NCOLS];
  logic [NCOLS-1:0] vld_q;
  logic [7:0]       rd_data_q;
  logic             rd_vld_q;
  logic [7:0]       rd_val;
  logic [7:0]       saved_q;
  logic [7:0]       prev_q;
  logic [3:0]       op_q;
  logic [2:0]       row_q;
  logic [7:0]       value_q;
  logic             rotate_q;
  logic             fill_zero_q;
  logic [2:0]       dev_m1;
  logic [5:0]       nlast_full;
  logic [7:0]       dot_mask;
  logic [7:0]       bound_val;
  logic [7:0]       new_col;
  logic             out_valid_q;
  logic             emit;

  always_comb begin
    if (dev_cnt_i == '0) begin
      dev_m1 = 3'd0;
    end else if (32'(dev_cnt_i) > MAX_DEVICES) begin
      dev_m1 = 3'(MAX_DEVICES - 1);
    end else begin
      dev_m1 = dev_cnt_i - 3'd1;
    end
  end

  assign nlast_full     = {dev_m1, 3'b111};
  assign nlast_o        = nlast_full[IDX_W-1:0];
  assign sts_o.in_range = {1'b0, column_i} <= nlast_full;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q        <= op_i;
      row_q       <= row_i;
      value_q     <= value_i;
      rotate_q    <= rotate_i;
      fill_zero_q <= fill_zero_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_col) begin
      mem_q[idx_i] <= new_col;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
      rd_vld_q  <= vld_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.clr_store) begin
      vld_q <= '0;
    end else if (cmd_i.emit_col) begin
      vld_q[idx_i] <= 1'b1;
    end
  end

  assign rd_val = rd_vld_q ? rd_data_q : 8'd0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_en) begin
      saved_q <= rd_val;
    end
    if (cmd_i.emit_col) begin
      prev_q <= rd_val;
    end
  end

  assign dot_mask  = 8'd1 << row_q;
  assign bound_val = rotate_q ? saved_q : (fill_zero_q ? 8'd0 : rd_val);

  always_comb begin
    unique case (op_q)
      OP_SET_COL: new_col = value_q;
      OP_SET_DOT: new_col = value_q[0] ? (rd_val | dot_mask) : (rd_val & ~dot_mask);
      OP_LEFT:    new_col = (idx_i == nlast_o) ? bound_val : rd_val;
      OP_RIGHT:   new_col = (idx_i == '0) ? bound_val : prev_q;
      OP_UP:      new_col = {rotate_q & rd_val[0], rd_val[7:1]};
      OP_DOWN:    new_col = {rd_val[6:0], rotate_q & rd_val[7]};
      default:    new_col = rd_val;
    endcase
  end

  assign emit = cmd_i.emit_col || cmd_i.emit_bc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_bc) begin
      to_all_o   <= 1'b1;
      device_o   <= 2'd0;
      reg_addr_o <= bc_addr(cmd_i.bc_step);
      reg_data_o <= bc_data(cmd_i.bc_step, value_q);
      last_o     <= cmd_i.last;
    end else if (cmd_i.emit_col) begin
      to_all_o   <= 1'b0;
      device_o   <= 2'(idx_i >> 3);
      reg_addr_o <= 4'(idx_i[2:0]) + REG_DIGIT_FIRST;
      reg_data_o <= new_col;
      last_o     <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/lmcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// LED matrix column scroller controller
// Accepts requests and sequences broadcast frames and column read-modify-
// write steps through the datapath.
// ----------------------------------------------------------------------------
module lmcs_ctrl #(
  parameter int unsigned MAX_DEVICES = 4,
  localparam int unsigned IDX_W = $clog2(MAX_DEVICES * 8)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        op_i,
  input  logic [4:0]        column_i,
  input  lmcs_pkg::dp_sts_t sts_i,
  input  logic [IDX_W-1:0]  nlast_i,
  output lmcs_pkg::dp_cmd_t cmd_o,
  output logic [IDX_W-1:0]  rd_addr_o,
  output logic [IDX_W-1:0]  idx_o
);
  import lmcs_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BC   = 3'd1;
  localparam logic [2:0] ST_PRE  = 3'd2;
  localparam logic [2:0] ST_SAVE = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [3:0]       op_q, op_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [3:0]       step_q, step_d;
  logic [IDX_W-1:0] col_addr;
  logic             single;
  logic             bc_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_INIT;
      idx_q   <= '0;
      step_q  <= BC_SCAN;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      step_q  <= step_d;
    end
  end

  assign col_addr = (op_q == OP_LEFT && idx_q != nlast_i) ? idx_q + IDX_W'(1) : idx_q;
  assign single   = (op_q == OP_SET_COL) || (op_q == OP_SET_DOT);
  assign bc_last  = (step_q == BC_DIGIT_LAST) || (step_q == BC_INTENSITY);
  assign idx_o    = idx_q;

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    idx_d          = idx_q;
    step_d         = step_q;
    cmd_o          = '0;
    cmd_o.bc_step  = step_q;
    rd_addr_o      = col_addr;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          op_d            = op_i;
          idx_d           = '0;
          unique case (op_i)
            OP_INIT: begin
              cmd_o.clr_store = 1'b1;
              step_d          = BC_SCAN;
              state_d         = ST_BC;
            end
            OP_CLEAR: begin
              cmd_o.clr_store = 1'b1;
              step_d          = BC_DIGIT_FIRST;
              state_d         = ST_BC;
            end
            OP_INTENSITY: begin
              step_d  = BC_INTENSITY;
              state_d = ST_BC;
            end
            OP_SET_COL, OP_SET_DOT: begin
              if (sts_i.in_range) begin
                idx_d   = IDX_W'(column_i);
                state_d = ST_RD;
              end
            end
            OP_LEFT, OP_RIGHT: state_d = ST_PRE;
            OP_UP, OP_DOWN:    state_d = ST_RD;
            default:           state_d = ST_IDLE;
          endcase
        end
      end
      ST_BC: begin
        if (sts_i.out_free) begin
          cmd_o.emit_bc = 1'b1;
          cmd_o.last    = bc_last;
          if (bc_last) begin
            state_d = ST_IDLE;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      ST_PRE: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = (op_q == OP_LEFT) ? '0 : nlast_i;
        state_d     = ST_SAVE;
      end
      ST_SAVE: begin
        cmd_o.save_en = 1'b1;
        cmd_o.rd_en   = 1'b1;
        state_d       = ST_WR;
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WR;
      end
      ST_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_col = 1'b1;
          cmd_o.last     = single || (idx_q == nlast_i);
          if (single || (idx_q == nlast_i)) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/led_matrix_column_scroller.sv @@
// ----------------------------------------------------------------------------
// LED matrix column scroller
// Column store and load frame generator for a chain of LED matrix drivers.
// ----------------------------------------------------------------------------
// One request is taken at a time while the block is idle; its frames then
// leave one by one through a single output register, so a frame may wait
// there while the next request is taken. Broadcast frames (init, clear,
// intensity) come out one per cycle after the request cycle while the
// output is not stalled: init sends the setup writes and the eight digit
// clears, clear only the digit clears and intensity only its own write.
// Column frames go through a read-modify-write of the column store, whose
// registered read means each column is read and then written and emitted:
// set column and set dot update one column, and a shift updates every
// active column; left and right first read the column that wraps around.
// Set column and set dot outside the active columns, and unknown
// operations, are taken and emit nothing. Output stalls hold these
// sequences. The store needs no clearing pass after reset; per-column
// valid bits make unwritten columns read as zero.
module led_matrix_column_scroller #(
  parameter int unsigned MAX_DEVICES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  op_i,
  input  logic [4:0]  column_i,
  input  logic [2:0]  row_i,
  input  logic [7:0]  value_i,
  input  logic        rotate_i,
  input  logic        fill_zero_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        to_all_o,
  output logic [1:0]  device_o,
  output logic [3:0]  reg_addr_o,
  output logic [7:0]  reg_data_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lmcs_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_DEVICES * 8);

  logic [DEV_CNT_W-1:0] dev_cnt_q;
  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     nlast;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - DEV_CNT_W){1'b0}}, dev_cnt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_cnt_q <= DEV_CNT_W'(4);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      dev_cnt_q <= pwdata[DEV_CNT_W-1:0];
    end
  end

  lmcs_ctrl #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .op_i      (op_i),
    .column_i  (column_i),
    .sts_i     (sts),
    .nlast_i   (nlast),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .idx_o     (idx)
  );

  lmcs_datapath #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rd_addr_i  (rd_addr),
    .idx_i      (idx),
    .nlast_o    (nlast),
    .dev_cnt_i  (dev_cnt_q),
    .op_i       (op_i),
    .column_i   (column_i),
    .row_i      (row_i),
    .value_i    (value_i),
    .rotate_i   (rotate_i),
    .fill_zero_i(fill_zero_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .to_all_o   (to_all_o),
    .device_o   (device_o),
    .reg_addr_o (reg_addr_o),
    .reg_data_o (reg_data_o),
    .last_o     (last_o)
  );

endmodule

@@ hw/rtl/lmcs_checker.sv @@
// ----------------------------------------------------------------------------
// LED matrix column scroller checker
// Port-level checks on the frame output, bound to the top level.
// ----------------------------------------------------------------------------
module lmcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       to_all_o,
  input logic [1:0] device_o,
  input logic [3:0] reg_addr_o,
  input logic [7:0] reg_data_o,
  input logic       last_o
);
  import lmcs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Frame dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable({to_all_o, device_o, reg_addr_o, reg_data_o, last_o}))
    else $error("Frame changed while stalled.");

  a_bc_device: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && to_all_o |-> device_o == 2'd0)
    else $error("Broadcast frame names a device.");

  a_col_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !to_all_o |->
      (reg_addr_o >= REG_DIGIT_FIRST && reg_addr_o <= REG_DIGIT_LAST))
    else $error("Targeted frame outside the digit registers.");

endmodule

bind led_matrix_column_scroller lmcs_checker u_lmcs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .to_all_o   (to_all_o),
  .device_o   (device_o),
  .reg_addr_o (reg_addr_o),
  .reg_data_o (reg_data_o),
  .last_o     (last_o)
);
